>>> hdl/clook_pkg.sv
`timescale 1ns / 1ps

package clook_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_SECTOR_BITS = 48;
    localparam int DEF_TAG_BITS    = 8;

    localparam int LIMIT_BITS   = 7;
    localparam int TICK_BITS    = 20;
    localparam int DIST_BITS    = 64;
    localparam int COUNT_BITS   = 32;
    localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = 7'd50;
    localparam logic [TICK_BITS-1:0]  DEFAULT_TICKS = 20'd50;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_WORK   = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SELECT,
        S_RESULT
    } fsm_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic shift_in;   // append at tail
        logic remove;     // remove the winner and close the gap
        logic wrap;       // rank against lowest overall
    } cell_ctrl_t;

    localparam int REG_MAX_REQUESTS  = 0;
    localparam int REG_TIMEOUT_TICKS = 1;

endpackage

>>> hdl/clook_cell.sv
`timescale 1ns / 1ps

// One queue slot. Holds an entry and computes its own rank flags against head.
module clook_cell
    import clook_pkg::*;
#(
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctrl_t             ctrl,
    input  logic                   load_here,     // this slot is the tail
    input  logic                   take_next,     // at or past the winner
    input  logic [SECTOR_BITS-1:0] new_sector,
    input  logic [TAG_BITS-1:0]    new_tag,
    input  logic [SECTOR_BITS-1:0] next_sector,   // neighbor above
    input  logic [TAG_BITS-1:0]    next_tag,
    input  logic                   next_valid,
    input  logic [SECTOR_BITS-1:0] head,
    output logic [SECTOR_BITS-1:0] sector,
    output logic [TAG_BITS-1:0]    tag,
    output logic                   valid,
    output logic                   ahead          // valid and at/above head
);

    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic                   valid_reg, valid_next;
    logic                   ahead_reg;

    always_comb begin
        sector_next = sector_reg;
        tag_next    = tag_reg;
        valid_next  = valid_reg;
        if (ctrl.shift_in && load_here) begin
            sector_next = new_sector;
            tag_next    = new_tag;
            valid_next  = 1'b1;
        end else if (ctrl.remove && take_next) begin
            sector_next = next_sector;
            tag_next    = next_tag;
            valid_next  = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        sector_reg <= sector_next;
        tag_reg    <= tag_next;
        ahead_reg  <= valid_reg && (sector_reg >= head);
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign sector = sector_reg;
    assign tag    = tag_reg;
    assign valid  = valid_reg;
    assign ahead  = ahead_reg && !ctrl.wrap;

endmodule

>>> hdl/clook_select.sv
`timescale 1ns / 1ps

// Registered tournament over the cell row: lowest key wins, lower index on ties.
module clook_select
    import clook_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    localparam int IDX_BITS   = $clog2(QUEUE_DEPTH)
) (
    input  logic                                  aclk,
    input  logic [QUEUE_DEPTH-1:0][SECTOR_BITS-1:0] sectors,
    input  logic [QUEUE_DEPTH-1:0]                eligible,
    output logic [IDX_BITS-1:0]                   win_idx,
    output logic                                  win_found
);

    localparam int LEAVES = 1 << IDX_BITS;
    localparam int LEVELS = IDX_BITS;
    localparam int CUT    = LEVELS / 2;

    logic [LEAVES-1:0][SECTOR_BITS-1:0] key   [LEVELS+1];
    logic [LEAVES-1:0][IDX_BITS-1:0]    idx   [LEVELS+1];
    logic [LEAVES-1:0]                  ok    [LEVELS+1];
    logic [LEAVES-1:0][SECTOR_BITS-1:0] key_reg;
    logic [LEAVES-1:0][IDX_BITS-1:0]    idx_reg;
    logic [LEAVES-1:0]                  ok_reg;

    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            if (i < QUEUE_DEPTH) begin
                key[0][i] = sectors[i];
                ok[0][i]  = eligible[i];
            end else begin
                key[0][i] = '0;
                ok[0][i]  = 1'b0;
            end
            idx[0][i] = IDX_BITS'(i);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < LEAVES; i++) begin
                key[l+1][i] = '0;
                idx[l+1][i] = '0;
                ok[l+1][i]  = 1'b0;
            end
            for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
                logic [SECTOR_BITS-1:0] ka, kb;
                logic oa, ob;
                ka = (l == CUT) ? key_reg[2*i]   : key[l][2*i];
                kb = (l == CUT) ? key_reg[2*i+1] : key[l][2*i+1];
                oa = (l == CUT) ? ok_reg[2*i]    : ok[l][2*i];
                ob = (l == CUT) ? ok_reg[2*i+1]  : ok[l][2*i+1];
                if (oa && (!ob || ka <= kb)) begin
                    key[l+1][i] = ka;
                    idx[l+1][i] = (l == CUT) ? idx_reg[2*i] : idx[l][2*i];
                end else begin
                    key[l+1][i] = kb;
                    idx[l+1][i] = (l == CUT) ? idx_reg[2*i+1] : idx[l][2*i+1];
                end
                ok[l+1][i] = oa || ob;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key[CUT];
        idx_reg <= idx[CUT];
        ok_reg  <= ok[CUT];
    end

    assign win_idx   = idx[LEVELS][0];
    assign win_found = ok[LEVELS][0];

endmodule

>>> hdl/clook_disk_request_scheduler_core.sv
`timescale 1ns / 1ps

// Channel   | Ports                      | Contents
// s_ (in)   | s_tvalid s_tready s_tdata  | command, request_sector, request_tag
// m_ (out)  | m_tvalid m_tready m_tdata  | status .. jump_total
// cfg       | cfg_we cfg_index cfg_wdata | batch limit, timeout ticks
//
// Insert, tick, idle command and refused dispatch load the result at the
// accepting edge. A granted dispatch steps through the flag, tree-stage and
// decide phases of S_SELECT, then S_RESULT loads its result: a tree
// split by one register stage picks the winner, then the row closes the gap.
// With no sector ahead the tree reruns in wrap mode from the tree-stage phase.
// aresetn is synchronous; it clears cell valid bits and all counters.
// The result register holds while m_tready is low; a new item is taken only
// once the previous result has been delivered.
module clook_disk_request_scheduler_core
    import clook_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int IDX_BITS   = $clog2(QUEUE_DEPTH),
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_RAW     = 2 + SECTOR_BITS + TAG_BITS,
    localparam int IN_BITS    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW    = 2 + TAG_BITS + SECTOR_BITS + 1 + 1 + CNT_BITS
                                + 2 * DIST_BITS + 3 * COUNT_BITS,
    localparam int OUT_BITS   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // command, request_sector, request_tag (lowest bit up)
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, granted_tag, granted_sector, circular_jump, work_ready,
    // pending_count, arrival-order seek, dispatch-order seek, dispatched_total,
    // received_total, jump_total (lowest bit up)
    output logic [OUT_BITS-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [TICK_BITS-1:0] cfg_wdata
);

    // Configuration
    logic [LIMIT_BITS-1:0] max_req_reg;
    logic [TICK_BITS-1:0]  timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_req_reg <= DEFAULT_LIMIT;
            timeout_reg <= DEFAULT_TICKS;
        end else if (cfg_we) begin
            if (cfg_index == 1'(REG_MAX_REQUESTS)) begin
                max_req_reg <= cfg_wdata[LIMIT_BITS-1:0];
            end else begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Input unpack
    cmd_t                   in_cmd;
    logic [SECTOR_BITS-1:0] in_sector;
    logic [TAG_BITS-1:0]    in_tag;
    assign in_cmd    = cmd_t'(s_tdata[1:0]);
    assign in_sector = s_tdata[2 +: SECTOR_BITS];
    assign in_tag    = s_tdata[2 + SECTOR_BITS +: TAG_BITS];

    // Control state
    fsm_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [CNT_BITS-1:0] held_reg, held_next;
    logic [SECTOR_BITS-1:0] head_reg, head_next, last_arr_reg, last_arr_next;
    logic [SECTOR_BITS-1:0] last_dsp_reg, last_dsp_next;
    logic arr_seen_reg, arr_seen_next, dsp_seen_reg, dsp_seen_next;
    logic [DIST_BITS-1:0] fcfs_reg, fcfs_next, clook_reg, clook_next;
    logic full_trig_reg, full_trig_next, tmo_trig_reg, tmo_trig_next;
    logic [TICK_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] dsp_cnt_reg, dsp_cnt_next, rcv_cnt_reg, rcv_cnt_next;
    logic [COUNT_BITS-1:0] jmp_cnt_reg, jmp_cnt_next;
    logic wrap_reg, wrap_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    status_t                r_status_reg, r_status_next;
    logic [TAG_BITS-1:0]    r_tag_reg, r_tag_next;
    logic [SECTOR_BITS-1:0] r_sec_reg, r_sec_next;
    logic                   r_jump_reg, r_jump_next;

    // Cell row
    cell_ctrl_t ctrl;
    logic [QUEUE_DEPTH-1:0][SECTOR_BITS-1:0] c_sector;
    logic [QUEUE_DEPTH-1:0][TAG_BITS-1:0]    c_tag;
    logic [QUEUE_DEPTH-1:0]                  c_valid, c_ahead;
    logic [IDX_BITS-1:0] win_idx;
    logic                win_found;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [SECTOR_BITS-1:0] nsec;
            logic [TAG_BITS-1:0]    ntag;
            logic                   nval;
            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign nsec = '0;
                assign ntag = '0;
                assign nval = 1'b0;
            end else begin : g_mid
                assign nsec = c_sector[g+1];
                assign ntag = c_tag[g+1];
                assign nval = c_valid[g+1];
            end
            clook_cell #(
                .SECTOR_BITS(SECTOR_BITS),
                .TAG_BITS   (TAG_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .load_here  (held_reg == CNT_BITS'(g)),
                .take_next  (IDX_BITS'(g) >= win_idx),
                .new_sector (in_sector),
                .new_tag    (in_tag),
                .next_sector(nsec),
                .next_tag   (ntag),
                .next_valid (nval),
                .head       (head_reg),
                .sector     (c_sector[g]),
                .tag        (c_tag[g]),
                .valid      (c_valid[g]),
                .ahead      (c_ahead[g])
            );
        end
    endgenerate

    clook_select #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .SECTOR_BITS(SECTOR_BITS)
    ) u_select (
        .aclk     (aclk),
        .sectors  (c_sector),
        .eligible (wrap_reg ? c_valid : c_ahead),
        .win_idx  (win_idx),
        .win_found(win_found)
    );

    logic work_avail;
    logic accept;
    assign work_avail = (full_trig_reg || tmo_trig_reg) && (held_reg != '0);
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [SECTOR_BITS-1:0] adiff(input logic [SECTOR_BITS-1:0] a,
                                                      input logic [SECTOR_BITS-1:0] b);
        adiff = (a > b) ? a - b : b - a;
    endfunction

    // Next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_cmd == CMD_DISPATCH && work_avail) begin
                    state_next = S_SELECT;
                    phase_next = '0;
                end
            end
            S_SELECT: begin
                // flags, tree stage, then decide (maybe retry with wrap)
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd2 && win_found) begin
                    state_next = S_RESULT;
                end else if (phase_reg == 2'd2) begin
                    phase_next = 2'd1;
                end
            end
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        held_next      = held_reg;
        head_next      = head_reg;
        last_arr_next  = last_arr_reg;
        last_dsp_next  = last_dsp_reg;
        arr_seen_next  = arr_seen_reg;
        dsp_seen_next  = dsp_seen_reg;
        fcfs_next      = fcfs_reg;
        clook_next     = clook_reg;
        full_trig_next = full_trig_reg;
        tmo_trig_next  = tmo_trig_reg;
        count_next     = count_reg;
        dsp_cnt_next   = dsp_cnt_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        jmp_cnt_next   = jmp_cnt_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg && !m_tready;
        r_status_next  = r_status_reg;
        r_tag_next     = r_tag_reg;
        r_sec_next     = r_sec_reg;
        r_jump_next    = r_jump_reg;
        ctrl           = '0;
        ctrl.wrap      = wrap_reg;

        unique case (state_reg)
            S_IDLE: begin
                wrap_next = 1'b0;
                if (accept) begin
                    r_status_next = ST_OK;
                    r_tag_next    = '0;
                    r_sec_next    = '0;
                    r_jump_next   = 1'b0;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (held_reg == CNT_BITS'(QUEUE_DEPTH)) begin
                                r_status_next  = ST_FULL;
                            end else begin
                                ctrl.shift_in = 1'b1;
                                held_next     = held_reg + CNT_BITS'(1);
                                rcv_cnt_next  = sat_inc(rcv_cnt_reg);
                                if (arr_seen_reg) begin
                                    fcfs_next = fcfs_reg
                                        + DIST_BITS'(adiff(in_sector, last_arr_reg));
                                end
                                last_arr_next = in_sector;
                                arr_seen_next = 1'b1;
                                if (32'(held_next) >= 32'((max_req_reg != '0)
                                        ? max_req_reg : DEFAULT_LIMIT)) begin
                                    full_trig_next = 1'b1;
                                end
                                tmo_trig_next = 1'b0;
                                count_next = (timeout_reg != '0) ? timeout_reg
                                                                 : DEFAULT_TICKS;
                            end
                            out_valid_next = 1'b1;
                        end
                        CMD_DISPATCH: begin
                            if (!work_avail) begin
                                full_trig_next = 1'b0;
                                tmo_trig_next  = 1'b0;
                                r_status_next  = ST_NO_WORK;
                                out_valid_next = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            if (count_reg != '0) begin
                                count_next = count_reg - TICK_BITS'(1);
                                if (count_reg == TICK_BITS'(1)) begin
                                    tmo_trig_next = 1'b1;
                                end
                            end
                            out_valid_next = 1'b1;
                        end
                        default: out_valid_next = 1'b1;
                    endcase
                end
            end
            S_SELECT: begin
                if (phase_reg == 2'd2 && !win_found) begin
                    wrap_next = 1'b1;
                end
            end
            S_RESULT: begin
                ctrl.remove   = 1'b1;
                r_status_next = ST_OK;
                r_tag_next    = c_tag[win_idx];
                r_sec_next    = c_sector[win_idx];
                r_jump_next   = wrap_reg;
                if (wrap_reg) begin
                    jmp_cnt_next = sat_inc(jmp_cnt_reg);
                end
                if (dsp_seen_reg) begin
                    clook_next = clook_reg
                        + DIST_BITS'(adiff(c_sector[win_idx], last_dsp_reg));
                end
                last_dsp_next  = c_sector[win_idx];
                dsp_seen_next  = 1'b1;
                head_next      = c_sector[win_idx];
                dsp_cnt_next   = sat_inc(dsp_cnt_reg);
                held_next      = held_reg - CNT_BITS'(1);
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        r_status_reg <= r_status_next;
        r_tag_reg    <= r_tag_next;
        r_sec_reg    <= r_sec_next;
        r_jump_reg   <= r_jump_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            held_reg      <= '0;
            head_reg      <= '0;
            last_arr_reg  <= '0;
            last_dsp_reg  <= '0;
            arr_seen_reg  <= 1'b0;
            dsp_seen_reg  <= 1'b0;
            fcfs_reg      <= '0;
            clook_reg     <= '0;
            full_trig_reg <= 1'b0;
            tmo_trig_reg  <= 1'b0;
            count_reg     <= '0;
            dsp_cnt_reg   <= '0;
            rcv_cnt_reg   <= '0;
            jmp_cnt_reg   <= '0;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            head_reg      <= head_next;
            last_arr_reg  <= last_arr_next;
            last_dsp_reg  <= last_dsp_next;
            arr_seen_reg  <= arr_seen_next;
            dsp_seen_reg  <= dsp_seen_next;
            fcfs_reg      <= fcfs_next;
            clook_reg     <= clook_next;
            full_trig_reg <= full_trig_next;
            tmo_trig_reg  <= tmo_trig_next;
            count_reg     <= count_next;
            dsp_cnt_reg   <= dsp_cnt_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            jmp_cnt_reg   <= jmp_cnt_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Totals are live registers; they only move when a new result is loaded.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({jmp_cnt_reg, rcv_cnt_reg, dsp_cnt_reg, clook_reg,
                                 fcfs_reg, held_reg, work_avail, r_jump_reg,
                                 r_sec_reg, r_tag_reg, r_status_reg});

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("pending count beyond depth");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input ready during dispatch");
    a_grant_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT) |-> (held_reg != '0))
        else $error("grant from empty row");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import clook_pkg::*;

    localparam int IN_W  = 64;
    localparam int OUT_W = 296;

    // One result item, highest field first so that it packs like m_tdata.
    typedef struct packed {
        logic [31:0] jump_total;
        logic [31:0] received_total;
        logic [31:0] dispatched_total;
        logic [63:0] sweep_seek;
        logic [63:0] arrival_seek;
        logic [6:0]  pending_count;
        logic        work_ready;
        logic        circular_jump;
        logic [47:0] granted_sector;
        logic [7:0]  granted_tag;
        logic [1:0]  status;
    } sched_result_t;

    // Scheduler model plus the queue of results still owed by the block.
    class sched_scoreboard;
        logic [6:0]  batch_limit;
        logic [19:0] timeout_ticks;
        logic [47:0] pend_sector[$];
        logic [7:0]  pend_tag[$];
        logic [47:0] head_pos, last_arrival, last_grant;
        logic        arrival_seen, grant_seen, full_trig, timeout_trig;
        logic [19:0] countdown;
        logic [63:0] fcfs_sum, clook_sum;
        logic [31:0] grants, arrivals, jumps;
        sched_result_t owed_q[$];
        int failures;

        function new();
            batch_limit = DEFAULT_LIMIT;
            timeout_ticks = DEFAULT_TICKS;
            head_pos = '0; last_arrival = '0; last_grant = '0;
            arrival_seen = 0; grant_seen = 0; full_trig = 0; timeout_trig = 0;
            countdown = '0; fcfs_sum = '0; clook_sum = '0;
            grants = '0; arrivals = '0; jumps = '0;
            failures = 0;
        endfunction

        function void write_reg(logic idx, logic [19:0] value);
            if (idx == REG_MAX_REQUESTS[0])
                batch_limit = value[6:0];
            else
                timeout_ticks = value;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        function logic [63:0] seek(logic [47:0] a, logic [47:0] b);
            return (a > b) ? {16'd0, a - b} : {16'd0, b - a};
        endfunction

        function logic busy();
            return (full_trig || timeout_trig) && pend_sector.size() > 0;
        endfunction

        // Apply one accepted item and queue the result it must produce.
        function void note_item(cmd_t cmd, logic [47:0] sec, logic [7:0] tag);
            sched_result_t r;
            int best;
            logic found;
            r = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_INSERT: begin
                    if (pend_sector.size() >= DEF_QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pend_sector.push_back(sec);
                        pend_tag.push_back(tag);
                        arrivals = bump(arrivals);
                        if (arrival_seen)
                            fcfs_sum += seek(sec, last_arrival);
                        last_arrival = sec;
                        arrival_seen = 1;
                        if (pend_sector.size() >= ((batch_limit == 0) ? 50 : batch_limit))
                            full_trig = 1;
                        timeout_trig = 0;
                        countdown = (timeout_ticks == 0) ? DEFAULT_TICKS : timeout_ticks;
                    end
                end
                CMD_DISPATCH: begin
                    if (!busy()) begin
                        full_trig = 0;
                        timeout_trig = 0;
                        r.status = ST_NO_WORK;
                    end else begin
                        // lowest sector at or above the head, earliest on ties
                        found = 0;
                        best = 0;
                        foreach (pend_sector[i])
                            if (pend_sector[i] >= head_pos &&
                                (!found || pend_sector[i] < pend_sector[best])) begin
                                best = i;
                                found = 1;
                            end
                        if (!found) begin
                            // wrap to the lowest sector overall
                            foreach (pend_sector[i])
                                if (pend_sector[i] < pend_sector[best])
                                    best = i;
                            r.circular_jump = 1;
                            jumps = bump(jumps);
                        end
                        r.granted_sector = pend_sector[best];
                        r.granted_tag = pend_tag[best];
                        if (grant_seen)
                            clook_sum += seek(r.granted_sector, last_grant);
                        last_grant = r.granted_sector;
                        grant_seen = 1;
                        head_pos = r.granted_sector;
                        grants = bump(grants);
                        pend_sector.delete(best);
                        pend_tag.delete(best);
                    end
                end
                CMD_TICK: begin
                    if (countdown != 0) begin
                        countdown--;
                        if (countdown == 0)
                            timeout_trig = 1;
                    end
                end
                default: ;
            endcase
            r.work_ready = busy();
            r.pending_count = 7'(pend_sector.size());
            r.arrival_seek = fcfs_sum;
            r.sweep_seek = clook_sum;
            r.dispatched_total = grants;
            r.received_total = arrivals;
            r.jump_total = jumps;
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            sched_result_t got, want;
            string bad;
            got = data[$bits(sched_result_t)-1:0];
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result item %h", got);
                return;
            end
            want = owed_q.pop_front();
            bad = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.granted_tag !== want.granted_tag) bad = {bad, " granted_tag"};
            if (got.granted_sector !== want.granted_sector) bad = {bad, " granted_sector"};
            if (got.circular_jump !== want.circular_jump) bad = {bad, " circular_jump"};
            if (got.work_ready !== want.work_ready) bad = {bad, " work_ready"};
            if (got.pending_count !== want.pending_count) bad = {bad, " pending_count"};
            if (got.arrival_seek !== want.arrival_seek) bad = {bad, " arrival_seek"};
            if (got.sweep_seek !== want.sweep_seek) bad = {bad, " sweep_seek"};
            if (got.dispatched_total !== want.dispatched_total)
                bad = {bad, " dispatched_total"};
            if (got.received_total !== want.received_total) bad = {bad, " received_total"};
            if (got.jump_total !== want.jump_total) bad = {bad, " jump_total"};
            if (bad != "") begin
                failures++;
                if (failures <= 10)
                    $display("mismatch in%s\n  expected %h\n  actual   %h", bad, want, got);
            end
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 0;
    logic             cfg_index = 0;
    logic [19:0]      cfg_wdata = '0;

    sched_scoreboard sched_sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int reload_ticks = 50;

    clook_disk_request_scheduler_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Check every delivered result item; stall the result channel at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sched_sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item, idling first at random; note it once accepted.
    task automatic send_item(cmd_t cmd, logic [47:0] sec, logic [7:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, tag, sec, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sched_sb.note_item(cmd, sec, tag);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result item has arrived.
    task automatic drain();
        s_tvalid <= 0;
        while (sched_sb.owed_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 0;
        sched_sb.write_reg(idx, value);
        if (idx == REG_TIMEOUT_TICKS[0])
            reload_ticks = (value == 0) ? 50 : value;
        @(posedge aclk);
    endtask

    // Mostly narrow sectors so ties and wraps are common; sometimes full width.
    function automatic logic [47:0] pick_sector();
        if ($urandom_range(3) == 0)
            return 48'({$urandom, $urandom});
        return 48'($urandom_range(31));
    endfunction

    task automatic send_ticks(int n);
        repeat (n) send_item(CMD_TICK, pick_sector(), 8'($urandom));
    endtask

    task automatic run_random(int target);
        int stop_at, kind, k;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                // batch: inserts, maybe a timeout, then dispatches
                k = $urandom_range(1, 10);
                repeat (k) send_item(CMD_INSERT, pick_sector(), 8'($urandom));
                if (reload_ticks <= 60 && $urandom_range(1) == 1)
                    send_ticks(reload_ticks + $urandom_range(0, 1) - 1);
                repeat ($urandom_range(1, k + 2))
                    send_item(CMD_DISPATCH, pick_sector(), 8'($urandom));
            end else if (kind < 72) begin
                // noise across all commands and fields
                repeat (5) send_item(cmd_t'($urandom_range(3)), 48'({$urandom, $urandom}),
                                     8'($urandom));
            end else if (kind < 75) begin
                // overfill the store, then empty it
                repeat (66) send_item(CMD_INSERT, pick_sector(), 8'($urandom));
                repeat (66) send_item(CMD_DISPATCH, pick_sector(), 8'($urandom));
            end else begin
                repeat (4) send_item($urandom_range(1) ? CMD_DISPATCH : CMD_TICK,
                                     pick_sector(), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: idle commands, field extremes, timeout, ties and a wrap.
        write_reg(REG_TIMEOUT_TICKS[0], 20'd2);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_NONE, '1, '1);
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 8'hFF);
        send_item(CMD_INSERT, 48'd0, 8'h00);
        send_item(CMD_INSERT, 48'd100, 8'h11);
        send_item(CMD_INSERT, 48'd100, 8'h22);
        send_item(CMD_DISPATCH, '0, '0);
        send_ticks(2);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_INSERT, 48'd50, 8'h33);
        send_ticks(2);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_DISPATCH, '0, '0);
        send_item(CMD_DISPATCH, '0, '0);
        drain();

        // Four phases, each with its own register values and idling mix.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MAX_REQUESTS[0], 20'd1);
                    write_reg(REG_TIMEOUT_TICKS[0], 20'd1);
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    write_reg(REG_MAX_REQUESTS[0], 20'd64);
                    write_reg(REG_TIMEOUT_TICKS[0], 20'hFFFFF);
                    send_idle_pct = 58; recv_stall_pct = 0;
                end
                2: begin
                    write_reg(REG_MAX_REQUESTS[0], 20'd0);
                    write_reg(REG_TIMEOUT_TICKS[0], 20'd0);
                    send_idle_pct = 0; recv_stall_pct = 58;
                end
                default: begin
                    write_reg(REG_MAX_REQUESTS[0], 20'($urandom_range(2, 20)));
                    write_reg(REG_TIMEOUT_TICKS[0], 20'($urandom_range(1, 6)));
                    send_idle_pct = 10; recv_stall_pct = 10;
                end
            endcase
            run_random(270);
            drain();
        end

        if (sched_sb.failures == 0 && sched_sb.owed_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hdl/clook_pkg.sv
hdl/clook_cell.sv
hdl/clook_select.sv
hdl/clook_disk_request_scheduler_core.sv
sim/testbench.sv
